// ----- hw/rtl/spl_pkg.sv -----
// Package for the stereo peak limiter: sequencer states, multiply jobs,
// register indexes and fixed-point constants.
// Depends on nothing; used by stereo_peak_limiter_core.
package spl_pkg;

    // Widths of the shared multiply unit and of the fixed levels.
    localparam int AW        = 48;   // A operand and rounded result, signed
    localparam int BW        = 25;   // B operand, signed
    localparam int PW        = 50;   // one partial product
    localparam int ACW       = 73;   // accumulator
    localparam int MUL_SPLIT = 24;   // A is taken in two halves of this size
    localparam int SH_Q16    = 16;
    localparam int SH_Q20    = 20;
    localparam int MW        = 36;   // scaled magnitude
    localparam int LW        = 24;   // limit level
    localparam int GW        = 24;   // squared gain
    localparam int DW        = 25;   // divisor
    localparam int NUMW      = 57;   // dividend
    localparam int CFG_W     = 20;   // configuration write data
    localparam int GAIN_W    = 20;
    localparam int COEF_W    = 17;

    localparam logic [20:0] Q20_ONE  = 21'd1048576;
    localparam logic [20:0] Q20_1P05 = 21'd1101005;
    localparam logic [19:0] Q20_0P8  = 20'd838861;
    localparam logic [18:0] Q20_0P25 = 19'd262144;
    localparam logic [16:0] Q16_ONE  = 17'd65536;
    localparam logic [MW-1:0] MAG_MAX = {MW{1'b1}};

    localparam logic [GAIN_W-1:0] GAIN_RESET  = 20'd65536;
    localparam logic [COEF_W-1:0] RISE_RESET  = 17'd6554;
    localparam logic [COEF_W-1:0] DECAY_RESET = 17'd66;
    localparam logic [LW-1:0]     LIMIT_RESET = 24'h100000;

    typedef enum logic [2:0] {
        REG_MASTER_GAIN      = 3'd0,
        REG_BOOST_THRESHOLD  = 3'd1,
        REG_BOOST_RATIO      = 3'd2,
        REG_CUTOFF_THRESHOLD = 3'd3,
        REG_CUTOFF_RATIO     = 3'd4,
        REG_RISE_COEF        = 3'd5,
        REG_DECAY_COEF       = 3'd6
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_MUL_ACC,
        ST_MUL_POST,
        ST_LEVEL,
        ST_DECIDE,
        ST_STEP_PREP,
        ST_DIV_INIT,
        ST_DIV_CHK,
        ST_DIV_RUN,
        ST_FINISH
    } state_t;

    typedef enum logic [3:0] {
        OP_G2,
        OP_ML,
        OP_MR,
        OP_BR,
        OP_T0,
        OP_TB,
        OP_U,
        OP_U105,
        OP_STEP,
        OP_DIVISOR
    } op_t;

endpackage

// ----- hw/rtl/stereo_peak_limiter_core.sv -----
// Stereo peak limiter core: gain, envelope follower and output scaling.
// Depends on spl_pkg for states, job codes and fixed-point constants.
//
// Usage:
//   Input channel (in_valid, in_stall, sample_left, sample_right, block_end)
//   takes one stereo word; output channel (out_valid, out_stall, out_left,
//   out_right, out_block_end) delivers one limited word for each input word.
//   A word moves at a clock edge with valid high and stall low.
//   Configuration is written through cfg_write_en, cfg_index and cfg_data;
//   the user must write it only while no word is in flight, which the
//   block does not enforce; index seven is ignored. Each word runs through
//   one shared 25x25 multiplier, in states MUL_LO, MUL_HI, MUL_ACC and
//   MUL_POST for each product, and then a two-lane restoring divider, one
//   quotient bit per cycle. in_stall is high until the word is finished,
//   so a new word is taken only once the last one is in the output register.
//   A finished word waits in the output register while out_stall is high;
//   the next input word is taken meanwhile and holds before its result
//   is written if the register is still full.
//   Reset sets the configuration registers to their defaults and the limit level to 1.0.
module stereo_peak_limiter_core
    import spl_pkg::*;
#(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write_en,
    input  logic [2:0]                    cfg_index,
    input  logic [CFG_W-1:0]              cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample_left,
    input  logic signed [SAMPLE_BITS-1:0] sample_right,
    input  logic                          block_end,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] out_left,
    output logic signed [SAMPLE_BITS-1:0] out_right,
    output logic                          out_block_end
);

    localparam int CW = $clog2(SAMPLE_BITS);
    localparam int HW = NUMW - SAMPLE_BITS;
    localparam logic [SAMPLE_BITS-1:0] OUT_TOP = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [SAMPLE_BITS-1:0] OUT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

    state_t state_reg, state_next;
    op_t    op_reg, op_next;

    logic [GAIN_W-1:0] master_gain_reg, boost_threshold_reg, boost_ratio_reg;
    logic [GAIN_W-1:0] cutoff_threshold_reg, cutoff_ratio_reg;
    logic [COEF_W-1:0] rise_coef_reg, decay_coef_reg;
    logic [LW-1:0]     limit_reg, limit_next;
    logic              out_valid_reg, out_valid_next;

    logic signed [AW-1:0]  a_reg, a_next, c_reg, c_next;
    logic signed [BW-1:0]  b_reg, b_next;
    logic                  sh20_reg, sh20_next;
    logic signed [PW-1:0]  prod_reg, prod_next;
    logic signed [ACW-1:0] acc_reg, acc_next;

    logic [SAMPLE_BITS-1:0] mag_l_reg, mag_l_next, mag_r_reg, mag_r_next;
    logic                   neg_l_reg, neg_l_next, neg_r_reg, neg_r_next;
    logic                   blk_reg, blk_next;
    logic [GW-1:0]          g2_reg, g2_next;
    logic [MW-1:0]          ml_reg, ml_next, mr_reg, mr_next, lvl_reg, lvl_next;
    logic signed [AW-1:0]   diff_reg, diff_next, brterm_reg, brterm_next;
    logic signed [AW-1:0]   target_reg, target_next;
    logic [DW-1:0]          d_reg, d_next;
    logic [NUMW-1:0]        num_l_reg, num_l_next, num_r_reg, num_r_next;
    logic [DW-1:0]          rem_l_reg, rem_l_next, rem_r_reg, rem_r_next;
    logic [SAMPLE_BITS-1:0] q_l_reg, q_l_next, q_r_reg, q_r_next;
    logic                   ovf_l_reg, ovf_l_next, ovf_r_reg, ovf_r_next;
    logic [CW-1:0]          count_reg, count_next;

    logic signed [SAMPLE_BITS-1:0] out_left_reg, out_left_next;
    logic signed [SAMPLE_BITS-1:0] out_right_reg, out_right_next;
    logic                          out_blk_reg, out_blk_next;

    logic signed [BW-1:0]  mul_x;
    logic signed [PW-1:0]  mul_p;
    logic signed [ACW-1:0] cterm;
    logic signed [ACW-1:0] acc_sh;
    logic signed [AW-1:0]  mres;
    logic [MW-1:0]         mres_sat;
    logic [LW-1:0]         lim_new;
    logic                  lim_ge_one;

    logic [LW-1:0]        cut_level, lim_level, thr_sel;
    logic                 gt_c, gt_l;
    logic signed [AW-1:0] lvl_diff, lim_s;

    logic [SAMPLE_BITS-1:0] mag_in_l, mag_in_r;
    logic [HW-1:0]          num_hi_l, num_hi_r;
    logic [DW:0]            trial_l, trial_r, trial_sub_l, trial_sub_r;
    logic                   ge_l, ge_r;
    logic                   accept, out_free;

    function automatic logic [SAMPLE_BITS-1:0] pack_out(
        input logic [SAMPLE_BITS-1:0] q,
        input logic                   ovf,
        input logic                   neg
    );
        logic [SAMPLE_BITS-1:0] v;
        if (neg) begin
            v = (ovf || (q > OUT_TOP)) ? OUT_TOP : (~q + SAMPLE_BITS'(1));
        end else begin
            v = (ovf || q[SAMPLE_BITS-1]) ? OUT_MAX : q;
        end
        return v;
    endfunction

    assign in_stall      = (state_reg != ST_IDLE);
    assign accept        = in_valid && !in_stall;
    assign out_free      = !out_valid_reg || !out_stall;
    assign out_valid     = out_valid_reg;
    assign out_left      = out_left_reg;
    assign out_right     = out_right_reg;
    assign out_block_end = out_blk_reg;

    assign mag_in_l = sample_left[SAMPLE_BITS-1] ? (~$unsigned(sample_left) + SAMPLE_BITS'(1))
                                                 : $unsigned(sample_left);
    assign mag_in_r = sample_right[SAMPLE_BITS-1] ? (~$unsigned(sample_right) + SAMPLE_BITS'(1))
                                                  : $unsigned(sample_right);

    // Shared multiplier: the A operand goes through in a low and a high half.
    assign mul_x = (state_reg == ST_MUL_LO) ? $signed({1'b0, a_reg[MUL_SPLIT-1:0]})
                                            : $signed({a_reg[AW-1], a_reg[AW-1:MUL_SPLIT]});
    assign mul_p = mul_x * b_reg;

    // The addend and the rounding half enter the sum together, below the shift.
    assign cterm = sh20_reg ? ACW'($signed({c_reg, 1'b1, {(SH_Q20-1){1'b0}}}))
                            : ACW'($signed({c_reg, 1'b1, {(SH_Q16-1){1'b0}}}));
    assign acc_sh = sh20_reg ? (acc_reg >>> SH_Q20) : (acc_reg >>> SH_Q16);
    assign mres   = acc_sh[AW-1:0];

    assign mres_sat = (mres > $signed(AW'(MAG_MAX))) ? MAG_MAX : mres[MW-1:0];
    assign lim_new  = mres[AW-1] ? '0 : ((|mres[AW-2:LW]) ? {LW{1'b1}} : mres[LW-1:0]);
    assign lim_ge_one = |lim_new[LW-1:SH_Q20];

    assign cut_level = {boost_threshold_reg, 4'd0};
    assign lim_level = {cutoff_threshold_reg, 4'd0};
    assign gt_c      = lvl_reg > MW'(cut_level);
    assign gt_l      = lvl_reg > MW'(lim_level);
    assign thr_sel   = gt_c ? lim_level : cut_level;
    assign lvl_diff  = $signed(AW'(lvl_reg)) + $signed(AW'(Q20_ONE)) - $signed(AW'(thr_sel));
    assign lim_s     = $signed(AW'(limit_reg));

    assign num_hi_l    = num_l_reg[NUMW-1:SAMPLE_BITS];
    assign num_hi_r    = num_r_reg[NUMW-1:SAMPLE_BITS];
    assign trial_l     = {rem_l_reg, q_l_reg[SAMPLE_BITS-1]};
    assign trial_r     = {rem_r_reg, q_r_reg[SAMPLE_BITS-1]};
    assign trial_sub_l = trial_l - {1'b0, d_reg};
    assign trial_sub_r = trial_r - {1'b0, d_reg};
    assign ge_l        = trial_l >= {1'b0, d_reg};
    assign ge_r        = trial_r >= {1'b0, d_reg};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_MUL_LO;
                end
            end
            ST_MUL_LO:    state_next = ST_MUL_HI;
            ST_MUL_HI:    state_next = ST_MUL_ACC;
            ST_MUL_ACC:   state_next = ST_MUL_POST;
            ST_MUL_POST:
            begin
                unique case (op_reg) inside
                    OP_G2, OP_ML, OP_BR, OP_T0, OP_U, OP_STEP: state_next = ST_MUL_LO;
                    OP_MR:                                   state_next = ST_LEVEL;
                    OP_TB, OP_U105:                          state_next = ST_STEP_PREP;
                    OP_DIVISOR:                              state_next = ST_DIV_INIT;
                    default:                                 state_next = ST_IDLE;
                endcase
            end
            ST_LEVEL:     state_next = ST_DECIDE;
            ST_DECIDE:    state_next = (gt_c != gt_l) ? ST_STEP_PREP : ST_MUL_LO;
            ST_STEP_PREP: state_next = ST_MUL_LO;
            ST_DIV_INIT:  state_next = ST_DIV_CHK;
            ST_DIV_CHK:   state_next = ST_DIV_RUN;
            ST_DIV_RUN:
            begin
                if (count_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        op_next        = op_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        sh20_next      = sh20_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        mag_l_next     = mag_l_reg;
        mag_r_next     = mag_r_reg;
        neg_l_next     = neg_l_reg;
        neg_r_next     = neg_r_reg;
        blk_next       = blk_reg;
        g2_next        = g2_reg;
        ml_next        = ml_reg;
        mr_next        = mr_reg;
        lvl_next       = lvl_reg;
        diff_next      = diff_reg;
        brterm_next    = brterm_reg;
        target_next    = target_reg;
        limit_next     = limit_reg;
        d_next         = d_reg;
        num_l_next     = num_l_reg;
        num_r_next     = num_r_reg;
        rem_l_next     = rem_l_reg;
        rem_r_next     = rem_r_reg;
        q_l_next       = q_l_reg;
        q_r_next       = q_r_reg;
        ovf_l_next     = ovf_l_reg;
        ovf_r_next     = ovf_r_reg;
        count_next     = count_reg;
        out_left_next  = out_left_reg;
        out_right_next = out_right_reg;
        out_blk_next   = out_blk_reg;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mag_l_next = mag_in_l;
                    mag_r_next = mag_in_r;
                    neg_l_next = sample_left[SAMPLE_BITS-1];
                    neg_r_next = sample_right[SAMPLE_BITS-1];
                    blk_next   = block_end;
                    a_next     = $signed(AW'(master_gain_reg));
                    b_next     = BW'(master_gain_reg);
                    c_next     = '0;
                    sh20_next  = 1'b0;
                    op_next    = OP_G2;
                end
            end
            ST_MUL_LO:
            begin
                prod_next = mul_p;
            end
            ST_MUL_HI:
            begin
                acc_next  = ACW'(prod_reg) + cterm;
                prod_next = mul_p;
            end
            ST_MUL_ACC:
            begin
                acc_next = acc_reg + (ACW'(prod_reg) <<< MUL_SPLIT);
            end
            ST_MUL_POST:
            begin
                c_next    = '0;
                sh20_next = 1'b0;
                unique case (op_reg)
                    OP_G2:
                    begin
                        g2_next = mres[GW-1:0];
                        a_next  = $signed(AW'(mag_l_reg));
                        b_next  = BW'(mres[GW-1:0]);
                        op_next = OP_ML;
                    end
                    OP_ML:
                    begin
                        ml_next = mres_sat;
                        a_next  = $signed(AW'(mag_r_reg));
                        b_next  = BW'(g2_reg);
                        op_next = OP_MR;
                    end
                    OP_MR:
                    begin
                        mr_next = mres_sat;
                    end
                    OP_BR:
                    begin
                        brterm_next = mres;
                        a_next      = diff_reg;
                        b_next      = BW'(Q20_0P8);
                        c_next      = $signed(AW'(Q20_0P25));
                        sh20_next   = 1'b1;
                        op_next     = OP_T0;
                    end
                    OP_T0:
                    begin
                        a_next  = mres;
                        b_next  = BW'(boost_ratio_reg);
                        c_next  = brterm_reg;
                        op_next = OP_TB;
                    end
                    OP_TB:
                    begin
                        target_next = mres;
                    end
                    OP_U:
                    begin
                        a_next    = mres;
                        b_next    = BW'(Q20_1P05);
                        sh20_next = 1'b1;
                        op_next   = OP_U105;
                    end
                    OP_U105:
                    begin
                        target_next = mres;
                    end
                    OP_STEP:
                    begin
                        limit_next = lim_new;
                        a_next     = $signed(AW'(lim_new));
                        b_next     = lim_ge_one ? BW'(Q20_1P05) : BW'(Q20_0P8);
                        c_next     = lim_ge_one ? '0 : $signed(AW'(Q20_0P25));
                        sh20_next  = 1'b1;
                        op_next    = OP_DIVISOR;
                    end
                    OP_DIVISOR:
                    begin
                        d_next = mres[DW-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_LEVEL:
            begin
                lvl_next = (ml_reg > mr_reg) ? ml_reg : mr_reg;
            end
            ST_DECIDE:
            begin
                c_next    = '0;
                sh20_next = 1'b0;
                if (!gt_c && !gt_l)
                begin
                    diff_next = lvl_diff;
                    a_next    = $signed(AW'(Q16_ONE)) - $signed(AW'(boost_ratio_reg));
                    b_next    = BW'(Q20_1P05);
                    op_next   = OP_BR;
                end else if (gt_c && gt_l)
                begin
                    a_next  = lvl_diff;
                    b_next  = BW'(cutoff_ratio_reg);
                    c_next  = $signed(AW'(Q20_ONE)) - $signed(AW'(lim_level));
                    op_next = OP_U;
                end else
                begin
                    target_next = $signed(AW'(Q20_1P05));
                end
            end
            ST_STEP_PREP:
            begin
                a_next    = target_reg - lim_s;
                b_next    = (lim_s < target_reg) ? BW'(rise_coef_reg) : BW'(decay_coef_reg);
                c_next    = lim_s;
                sh20_next = 1'b0;
                op_next   = OP_STEP;
            end
            ST_DIV_INIT:
            begin
                num_l_next = NUMW'({ml_reg, {SH_Q20{1'b0}}}) + NUMW'(d_reg[DW-1:1]);
                num_r_next = NUMW'({mr_reg, {SH_Q20{1'b0}}}) + NUMW'(d_reg[DW-1:1]);
            end
            ST_DIV_CHK:
            begin
                ovf_l_next = num_hi_l >= HW'(d_reg);
                ovf_r_next = num_hi_r >= HW'(d_reg);
                rem_l_next = num_hi_l[DW-1:0];
                rem_r_next = num_hi_r[DW-1:0];
                q_l_next   = num_l_reg[SAMPLE_BITS-1:0];
                q_r_next   = num_r_reg[SAMPLE_BITS-1:0];
                count_next = CW'(SAMPLE_BITS - 1);
            end
            ST_DIV_RUN:
            begin
                rem_l_next = ge_l ? trial_sub_l[DW-1:0] : trial_l[DW-1:0];
                rem_r_next = ge_r ? trial_sub_r[DW-1:0] : trial_r[DW-1:0];
                q_l_next   = {q_l_reg[SAMPLE_BITS-2:0], ge_l};
                q_r_next   = {q_r_reg[SAMPLE_BITS-2:0], ge_r};
                count_next = count_reg - CW'(1);
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_left_next  = $signed(pack_out(q_l_reg, ovf_l_reg, neg_l_reg));
                    out_right_next = $signed(pack_out(q_r_reg, ovf_r_reg, neg_r_reg));
                    out_blk_next   = blk_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= ST_IDLE;
            out_valid_reg        <= 1'b0;
            limit_reg            <= LIMIT_RESET;
            master_gain_reg      <= GAIN_RESET;
            boost_threshold_reg  <= GAIN_RESET;
            boost_ratio_reg      <= GAIN_RESET;
            cutoff_threshold_reg <= GAIN_RESET;
            cutoff_ratio_reg     <= GAIN_RESET;
            rise_coef_reg        <= RISE_RESET;
            decay_coef_reg       <= DECAY_RESET;
        end else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            limit_reg     <= limit_next;
            if (cfg_write_en)
            begin
                unique case (cfg_index)
                    REG_MASTER_GAIN:      master_gain_reg      <= cfg_data[GAIN_W-1:0];
                    REG_BOOST_THRESHOLD:  boost_threshold_reg  <= cfg_data[GAIN_W-1:0];
                    REG_BOOST_RATIO:      boost_ratio_reg      <= cfg_data[GAIN_W-1:0];
                    REG_CUTOFF_THRESHOLD: cutoff_threshold_reg <= cfg_data[GAIN_W-1:0];
                    REG_CUTOFF_RATIO:     cutoff_ratio_reg     <= cfg_data[GAIN_W-1:0];
                    REG_RISE_COEF:        rise_coef_reg        <= cfg_data[COEF_W-1:0];
                    REG_DECAY_COEF:       decay_coef_reg       <= cfg_data[COEF_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        c_reg         <= c_next;
        sh20_reg      <= sh20_next;
        prod_reg      <= prod_next;
        acc_reg       <= acc_next;
        mag_l_reg     <= mag_l_next;
        mag_r_reg     <= mag_r_next;
        neg_l_reg     <= neg_l_next;
        neg_r_reg     <= neg_r_next;
        blk_reg       <= blk_next;
        g2_reg        <= g2_next;
        ml_reg        <= ml_next;
        mr_reg        <= mr_next;
        lvl_reg       <= lvl_next;
        diff_reg      <= diff_next;
        brterm_reg    <= brterm_next;
        target_reg    <= target_next;
        d_reg         <= d_next;
        num_l_reg     <= num_l_next;
        num_r_reg     <= num_r_next;
        rem_l_reg     <= rem_l_next;
        rem_r_reg     <= rem_r_next;
        q_l_reg       <= q_l_next;
        q_r_reg       <= q_r_next;
        ovf_l_reg     <= ovf_l_next;
        ovf_r_reg     <= ovf_r_next;
        count_reg     <= count_next;
        out_left_reg  <= out_left_next;
        out_right_reg <= out_right_next;
        out_blk_reg   <= out_blk_next;
    end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// Testbench for stereo_peak_limiter_core: directed and random stereo words under random
// idling on both channels, each limited word checked against a built-in limiter model.
// Depends on spl_pkg and the stereo_peak_limiter_core RTL.
module testbench
    import spl_pkg::*;
();

    localparam int SAMPLE_BITS = 24;
    localparam logic [2:0] CFG_INDEX_IGNORED = 3'd7;

    localparam longint LVL_ONE = 1048576;
    localparam longint LVL_1P05 = 1101005;
    localparam longint LVL_0P8 = 838861;
    localparam longint LVL_0P25 = 262144;
    localparam longint RATIO_ONE = 65536;
    localparam longint MAG_LIMIT = 64'd68719476735;
    localparam longint LEVEL_LIMIT = 16777215;
    localparam longint SAMPLE_TOP = 8388608;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        sample_t left;
        sample_t right;
        logic    block_end;
    } frame_t;

    typedef struct {
        sample_t left;
        sample_t right;
        logic    block_end;
        bit      known;
        sample_t exp_left;
        sample_t exp_right;
    } stim_row_t;

    typedef enum int {
        CURVE_BOOST,
        CURVE_FLAT,
        CURVE_CUTOFF
    } curve_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_write_en;
    logic [2:0]       cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic             in_valid;
    logic             in_stall;
    sample_t          sample_left;
    sample_t          sample_right;
    logic             block_end;
    logic             out_valid;
    logic             out_stall;
    sample_t          out_left;
    sample_t          out_right;
    logic             out_block_end;

    bit [19:0] lim_gain;
    bit [19:0] lim_boost_thr;
    bit [19:0] lim_boost_ratio;
    bit [19:0] lim_cut_thr;
    bit [19:0] lim_cut_ratio;
    bit [16:0] lim_rise;
    bit [16:0] lim_decay;
    longint    env_level;

    frame_t pending_frames[$];
    int     mismatch_count = 0;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    int     long_hold_left = 0;

    stim_row_t directed_rows [16] = '{
        '{24'sh000000, 24'sh000000, 1'b0, 1'b1, 24'sh000000, 24'sh000000},
        '{24'sh000000, 24'sh000000, 1'b1, 1'b1, 24'sh000000, 24'sh000000},
        '{24'sh7FFFFF, 24'sh800000, 1'b0, 1'b0, 24'sh000000, 24'sh000000},
        '{24'sh800000, 24'sh7FFFFF, 1'b1, 1'b0, 24'sh000000, 24'sh000000},
        '{24'sh000001, 24'shFFFFFF, 1'b0, 1'b0, 24'sh000000, 24'sh000000},
        '{24'shFFFFFF, 24'sh000001, 1'b0, 1'b0, 24'sh000000, 24'sh000000},
        '{24'sh555555, 24'shAAAAAA, 1'b1, 1'b0, 24'sh000000, 24'sh000000},
        '{24'shAAAAAA, 24'sh555555, 1'b0, 1'b0, 24'sh000000, 24'sh000000},
        '{24'sh100000, 24'shF00000, 1'b0, 1'b0, 24'sh000000, 24'sh000000},
        '{24'sh0FFFFF, 24'sh000000, 1'b0, 1'b0, 24'sh000000, 24'sh000000},
        '{24'sh7FFFFF, 24'sh7FFFFF, 1'b0, 1'b0, 24'sh000000, 24'sh000000},
        '{24'sh7FFFFF, 24'sh7FFFFF, 1'b1, 1'b0, 24'sh000000, 24'sh000000},
        '{24'sh7FFFFF, 24'sh7FFFFF, 1'b0, 1'b0, 24'sh000000, 24'sh000000},
        '{24'sh0003E8, 24'shFFFC18, 1'b0, 1'b0, 24'sh000000, 24'sh000000},
        '{24'sh000000, 24'sh000000, 1'b0, 1'b1, 24'sh000000, 24'sh000000},
        '{24'sh040000, 24'sh040000, 1'b1, 1'b0, 24'sh000000, 24'sh000000}
    };

    stereo_peak_limiter_core #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write_en(cfg_write_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .sample_left(sample_left),
        .sample_right(sample_right),
        .block_end(block_end),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_left(out_left),
        .out_right(out_right),
        .out_block_end(out_block_end)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic longint round_shift(longint p, int n);
        longint half;
        half = longint'(1) << (n - 1);
        if (p >= 0)
            return (p + half) >>> n;
        return -((-p + half - 1) >>> n);
    endfunction

    function automatic longint scaled_mag(sample_t s, longint g2);
        longint m;
        m = (s < 0) ? -longint'(s) : longint'(s);
        m = (m * g2 + 32768) >>> 16;
        return (m > MAG_LIMIT) ? MAG_LIMIT : m;
    endfunction

    function automatic sample_t saturate_sample(longint q, bit neg);
        if (neg)
            return sample_t'(-((q > SAMPLE_TOP) ? SAMPLE_TOP : q));
        return sample_t'((q > SAMPLE_TOP - 1) ? SAMPLE_TOP - 1 : q);
    endfunction

    // Advances the envelope by one frame and returns the limited frame.
    function automatic frame_t limit_frame(sample_t l, sample_t r, logic be);
        longint g2;
        longint ml;
        longint mr;
        longint lvl;
        longint ct;
        longint lt;
        longint br;
        longint lr;
        longint t;
        longint u;
        longint target;
        longint coef;
        longint d;
        curve_t curve;
        frame_t res;
        g2 = (longint'(lim_gain) * longint'(lim_gain) + 32768) >>> 16;
        ml = scaled_mag(l, g2);
        mr = scaled_mag(r, g2);
        lvl = (ml > mr) ? ml : mr;
        ct = longint'(lim_boost_thr) << 4;
        lt = longint'(lim_cut_thr) << 4;
        br = longint'(lim_boost_ratio);
        lr = longint'(lim_cut_ratio);
        curve = curve_t'(int'(lvl > ct) + int'(lvl > lt));
        case (curve)
            CURVE_BOOST:
            begin
                t = round_shift((lvl + LVL_ONE - ct) * LVL_0P8, 20) + LVL_0P25;
                target = round_shift(t * br, 16)
                       + round_shift((RATIO_ONE - br) * LVL_1P05, 16);
            end
            CURVE_FLAT:
                target = LVL_1P05;
            default:
            begin
                u = round_shift((lvl + LVL_ONE - lt) * lr, 16) + LVL_ONE - lt;
                target = round_shift(u * LVL_1P05, 20);
            end
        endcase
        coef = (env_level < target) ? longint'(lim_rise) : longint'(lim_decay);
        env_level = env_level + round_shift((target - env_level) * coef, 16);
        if (env_level < 0)
            env_level = 0;
        if (env_level > LEVEL_LIMIT)
            env_level = LEVEL_LIMIT;
        if (env_level >= LVL_ONE)
            d = round_shift(env_level * LVL_1P05, 20);
        else
            d = round_shift(env_level * LVL_0P8, 20) + LVL_0P25;
        res.left = saturate_sample(((ml << 20) + d / 2) / d, l < 0);
        res.right = saturate_sample(((mr << 20) + d / 2) / d, r < 0);
        res.block_end = be;
        return res;
    endfunction

    function automatic sample_t random_sample();
        int kind;
        sample_t v;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2, 3: v = sample_t'($urandom);
            4, 5, 6: v = sample_t'($urandom_range(0, 262143));
            7: v = sample_t'($urandom_range(24'h600000, 24'h7FFFFF));
            8: v = ($urandom_range(0, 1) != 0) ? 24'sh7FFFFF : 24'sh800000;
            default: v = sample_t'($urandom_range(0, 255));
        endcase
        if (kind >= 4 && kind != 8 && $urandom_range(0, 1) != 0)
            v = -v;
        return v;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // Offers one word, starting and ending at a falling edge.
    task automatic send_word(input sample_t l, input sample_t r, input logic be);
        int gap;
        gap = 0;
        while (gap < 30 && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        sample_left <= l;
        sample_right <= r;
        block_end <= be;
        do
            @(posedge clk);
        while (in_stall);
        pending_frames.push_back(limit_frame(l, r, be));
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_frames.size() != 0);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [CFG_W-1:0] value);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        case (idx)
            REG_MASTER_GAIN: lim_gain = value;
            REG_BOOST_THRESHOLD: lim_boost_thr = value;
            REG_BOOST_RATIO: lim_boost_ratio = value;
            REG_CUTOFF_THRESHOLD: lim_cut_thr = value;
            REG_CUTOFF_RATIO: lim_cut_ratio = value;
            REG_RISE_COEF: lim_rise = value[COEF_W-1:0];
            REG_DECAY_COEF: lim_decay = value[COEF_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(
        input logic [CFG_W-1:0] gain,
        input logic [CFG_W-1:0] boost_thr,
        input logic [CFG_W-1:0] boost_ratio,
        input logic [CFG_W-1:0] cut_thr,
        input logic [CFG_W-1:0] cut_ratio,
        input logic [CFG_W-1:0] rise,
        input logic [CFG_W-1:0] decay
    );
        write_reg(REG_MASTER_GAIN, gain);
        write_reg(REG_BOOST_THRESHOLD, boost_thr);
        write_reg(REG_BOOST_RATIO, boost_ratio);
        write_reg(REG_CUTOFF_THRESHOLD, cut_thr);
        write_reg(REG_CUTOFF_RATIO, cut_ratio);
        write_reg(REG_RISE_COEF, rise);
        write_reg(REG_DECAY_COEF, decay);
        write_reg(CFG_INDEX_IGNORED, CFG_W'($urandom));
        cfg_write_en <= 1'b0;
    endtask

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_left > 0)
            begin
                out_stall <= 1'b1;
                long_hold_left--;
            end
            else
                out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        frame_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_frames.size() == 0)
                report_mismatch($sformatf("unexpected word L=%0d R=%0d", out_left, out_right));
            else
            begin
                want = pending_frames.pop_front();
                if (out_left !== want.left)
                    report_mismatch($sformatf("out_left %0d, want %0d", out_left, want.left));
                if (out_right !== want.right)
                    report_mismatch($sformatf("out_right %0d, want %0d", out_right, want.right));
                if (out_block_end !== want.block_end)
                    report_mismatch($sformatf("out_block_end %0b, want %0b",
                        out_block_end, want.block_end));
            end
        end
    end

    initial
    begin
        #8000000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        stim_row_t row;
        int style;
        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index = REG_MASTER_GAIN;
        cfg_data = '0;
        in_valid = 1'b0;
        sample_left = '0;
        sample_right = '0;
        block_end = 1'b0;
        lim_gain = 20'd65536;
        lim_boost_thr = 20'd65536;
        lim_boost_ratio = 20'd65536;
        lim_cut_thr = 20'd65536;
        lim_cut_ratio = 20'd65536;
        lim_rise = 17'd6554;
        lim_decay = 17'd66;
        env_level = LVL_ONE;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            send_word(row.left, row.right, row.block_end);
            if (row.known)
            begin
                pending_frames[pending_frames.size() - 1].left = row.exp_left;
                pending_frames[pending_frames.size() - 1].right = row.exp_right;
            end
        end

        // A hugely negative target drives the level to zero and the divisor to its floor.
        wait_drained();
        apply_settings(20'h10000, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'h10000, 20'h10000,
            20'h10000);
        send_word(24'sh200000, 24'shE00000, 1'b0);
        send_word(24'sh012345, 24'sh7FFFFF, 1'b1);
        send_word(24'sh000000, 24'sh000000, 1'b0);

        // Full gain into a steep cutoff with an oversized rise step pins the level at its top.
        wait_drained();
        apply_settings(20'hFFFFF, 20'h00000, 20'h00000, 20'h00000, 20'hFFFFF, 20'hFFFFF,
            20'h00000);
        send_word(24'sh7FFFFF, 24'sh800000, 1'b1);
        send_word(24'sh400000, 24'shC00000, 1'b0);
        send_word(24'sh000001, 24'shFFFFFF, 1'b0);

        for (int phase = 0; phase < 12; phase++)
        begin
            wait_drained();
            style = $urandom_range(0, 9);
            if (phase == 3)
                apply_settings(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF,
                    20'hFFFFF, 20'hFFFFF);
            else if (phase == 8)
                apply_settings(20'h0, 20'h0, 20'h0, 20'h0, 20'h0, 20'h0, 20'h0);
            else if (phase == 10 || style == 0)
                apply_settings(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                    CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                    CFG_W'($urandom));
            else
                apply_settings(CFG_W'($urandom_range(32768, 131072)),
                    CFG_W'($urandom_range(8192, 131072)),
                    CFG_W'($urandom_range(0, 262144)), CFG_W'($urandom_range(32768, 262144)),
                    CFG_W'($urandom_range(0, 655360)), CFG_W'($urandom_range(0, 65536)),
                    CFG_W'($urandom_range(0, 65536)));
            case (phase % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 67;
                    recv_idle_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 67;
                end
                default:
                begin
                    send_idle_pct = 20;
                    recv_idle_pct = 20;
                end
            endcase
            if (phase == 4)
                long_hold_left = 400;
            for (int k = 0; k < 108; k++)
            begin
                if (phase == 6 && k == 54)
                    wait_drained();
                send_word(random_sample(), random_sample(), $urandom_range(0, 5) == 0);
            end
        end

        wait_drained();
        repeat (80) @(negedge clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
